### sv/ptd_pkg.sv
// shared constants and types of the periodic task dispatcher
`default_nettype none
package ptd_pkg;
    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAX_OUT   = 8;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);

    localparam int TICK_W     = 64;
    localparam int DIGIT_W    = 8;
    localparam int DIV_STEPS  = TICK_W / DIGIT_W;
    localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ERR  = 2'd1;
    localparam logic [1:0] STAT_DUE  = 2'd2;
    localparam logic [1:0] STAT_IDLE = 2'd3;

    typedef struct packed {
        logic [7:0] period;
        logic [7:0] handler;
    } ptd_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } ptd_div_stat_t;
endpackage
`default_nettype wire

### sv/ptd_slot_ram.sv
// task slot table: one write port, one registered read port
`default_nettype none
module ptd_slot_ram
    import ptd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [SLOT_W-1:0] waddr,
    input  wire ptd_entry_t        wdata,
    input  wire logic              re,
    input  wire logic [SLOT_W-1:0] raddr,
    output ptd_entry_t             rdata
);
    ptd_entry_t mem [NUM_SLOTS];
    ptd_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### sv/ptd_mod_unit.sv
// serial 64-by-8 remainder, one 8-bit digit per cycle, reports remainder zero
`default_nettype none
module ptd_mod_unit
    import ptd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [TICK_W-1:0] dividend,
    input  wire logic [7:0]        divisor,
    output ptd_div_stat_t          stat
);
    logic                 busy_reg;
    logic                 done_reg;
    logic                 zero_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TICK_W-1:0]    sh_reg;
    logic [7:0]           rem_reg;
    logic [7:0]           dvs_reg;
    logic [7:0]           rem_next;

    // restoring steps, remainder stays below the divisor so one subtract suffices
    always_comb begin
        logic [8:0] t;
        logic [7:0] r;
        r = rem_reg;
        t = '0;
        for (int k = 0; k < DIGIT_W; k++) begin
            t = {r, sh_reg[TICK_W-1-k]};
            if (t >= {1'b0, dvs_reg}) begin
                t = t - {1'b0, dvs_reg};
            end
            r = t[7:0];
        end
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                sh_reg   <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                sh_reg  <= sh_reg << DIGIT_W;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    zero_reg <= (rem_next == 8'd0);
                end
            end
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.rem_zero = zero_reg;
endmodule
`default_nettype wire

### sv/periodic_task_dispatcher.sv
// Periodic task dispatcher: a table of task slots in a RAM with a registered read, valid
// bits in flops, and a 64-bit tick count. Create, delete and unknown requests give one
// word. A tick walks every slot in priority order: an empty slot takes a RAM read, a
// check and a step to the next slot; an occupied one takes a RAM read, a check, a run of
// the serial 64-by-8 remainder unit up to its done pulse and a step, plus an emit when it
// is due. A tick ends with a final word; a step that sends a word waits while the output
// register still holds an unaccepted word. One request is handled at a time; a new
// request is taken while the last result word still waits in the output register.
`default_nettype none
module periodic_task_dispatcher
    import ptd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_req_type,
    input  wire logic [2:0] s_slot,
    input  wire logic [7:0] s_period,
    input  wire logic [7:0] s_handler,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_status,
    output logic [2:0]      m_due_slot,
    output logic [7:0]      m_due_handler,
    output logic            m_last
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;
    localparam logic [2:0] S_NEXT = 3'd6;
    localparam logic [2:0] S_END  = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [1:0]           req_type_reg, req_type_next;
    logic [2:0]           req_slot_reg, req_slot_next;
    logic [7:0]           req_period_reg, req_period_next;
    logic [7:0]           req_handler_reg, req_handler_next;
    logic [NUM_SLOTS-1:0] vbits_reg, vbits_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [2:0]           pend_slot_reg, pend_slot_next;
    logic [7:0]           pend_handler_reg, pend_handler_next;
    logic [7:0]           cur_handler_reg, cur_handler_next;
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic [2:0]           m_slot_reg, m_slot_next;
    logic [7:0]           m_handler_reg, m_handler_next;
    logic                 m_last_reg, m_last_next;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    ptd_entry_t        ram_wdata;
    logic              ram_re;
    ptd_entry_t        ram_rdata;
    logic              div_start;
    ptd_div_stat_t     div_stat;

    logic              out_free;
    logic              accept;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot_addr;
    logic              ok;

    ptd_slot_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    ptd_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tick_reg),
        .divisor  (ram_rdata.period),
        .stat     (div_stat)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_ok   = (32'(req_slot_reg) < 32'(NUM_SLOTS));
    assign slot_addr = SLOT_W'(req_slot_reg);

    always_comb begin
        state_next        = state_reg;
        req_type_next     = req_type_reg;
        req_slot_next     = req_slot_reg;
        req_period_next   = req_period_reg;
        req_handler_next  = req_handler_reg;
        vbits_next        = vbits_reg;
        tick_next         = tick_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;
        pend_handler_next = pend_handler_reg;
        cur_handler_next  = cur_handler_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_slot_next       = m_slot_reg;
        m_handler_next    = m_handler_reg;
        m_last_next       = m_last_reg;
        ram_we            = 1'b0;
        ram_waddr         = slot_addr;
        ram_wdata         = '0;
        ram_re            = 1'b0;
        div_start         = 1'b0;
        ok                = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_type_next    = s_req_type;
                    req_slot_next    = s_slot;
                    req_period_next  = s_period;
                    req_handler_next = s_handler;
                    if (s_req_type == REQ_TICK) begin
                        tick_next       = tick_reg + 1'b1;
                        idx_next        = '0;
                        cnt_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_RD;
                    end else begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    case (req_type_reg)
                        REQ_CREATE: begin
                            ok = slot_ok && !vbits_reg[slot_addr] && (req_period_reg != 8'd0);
                            if (ok) begin
                                vbits_next[slot_addr] = 1'b1;
                                ram_we                = 1'b1;
                                ram_wdata.period      = req_period_reg;
                                ram_wdata.handler     = req_handler_reg;
                            end
                        end
                        REQ_DELETE: begin
                            ok = slot_ok && vbits_reg[slot_addr];
                            if (ok) begin
                                vbits_next[slot_addr] = 1'b0;
                                ram_we                = 1'b1;
                            end
                        end
                        default: ok = 1'b0;
                    endcase
                    m_valid_next   = 1'b1;
                    m_status_next  = ok ? STAT_OK : STAT_ERR;
                    m_slot_next    = '0;
                    m_handler_next = '0;
                    m_last_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD: begin
                ram_re     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                cur_handler_next = ram_rdata.handler;
                if (vbits_reg[idx_reg]) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    state_next = div_stat.rem_zero ? S_EMIT : S_NEXT;
                end
            end
            S_EMIT: begin
                // the held due word goes out only once a later one shows it is not last
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next   = 1'b1;
                        m_status_next  = STAT_DUE;
                        m_slot_next    = pend_slot_reg;
                        m_handler_next = pend_handler_reg;
                        m_last_next    = 1'b0;
                    end
                    pend_valid_next   = 1'b1;
                    pend_slot_next    = 3'(idx_reg);
                    pend_handler_next = cur_handler_reg;
                    cnt_next          = cnt_reg + 1'b1;
                    state_next        = S_NEXT;
                end
            end
            S_NEXT: begin
                if (idx_reg == SLOT_W'(NUM_SLOTS - 1) || cnt_reg == CNT_W'(MAX_OUT)) begin
                    state_next = S_END;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_END: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_status_next   = pend_valid_reg ? STAT_DUE : STAT_IDLE;
                    m_slot_next     = pend_valid_reg ? pend_slot_reg : 3'd0;
                    m_handler_next  = pend_valid_reg ? pend_handler_reg : 8'd0;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            vbits_reg      <= '0;
            tick_reg       <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            vbits_reg      <= vbits_next;
            tick_reg       <= tick_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        req_type_reg     <= req_type_next;
        req_slot_reg     <= req_slot_next;
        req_period_reg   <= req_period_next;
        req_handler_reg  <= req_handler_next;
        pend_slot_reg    <= pend_slot_next;
        pend_handler_reg <= pend_handler_next;
        cur_handler_reg  <= cur_handler_next;
        m_status_reg     <= m_status_next;
        m_slot_reg       <= m_slot_next;
        m_handler_reg    <= m_handler_next;
        m_last_reg       <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_due_slot    = m_slot_reg;
    assign m_due_handler = m_handler_reg;
    assign m_last        = m_last_reg;

    // an occupied slot never holds a zero period
    a_period_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK && vbits_reg[idx_reg]) |-> (ram_rdata.period != 8'd0))
        else $error("occupied slot read back with zero period");

    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("remainder unit restarted while busy");

    a_single_word_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == STAT_OK || m_status_reg == STAT_ERR
                         || m_status_reg == STAT_IDLE)) |-> m_last_reg)
        else $error("single result word without last");

    a_idle_word_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == STAT_IDLE) |->
        (m_slot_reg == 3'd0 && m_handler_reg == 8'd0))
        else $error("idle word carries slot data");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != S_IDLE))
        else $error("request accepted but not processed");
endmodule
`default_nettype wire
